FILE: rtl/bcd_pkg.sv
// Shared types and constants for the button click discriminator.
`default_nettype none
package bcd_pkg;

  typedef enum logic [1:0] {
    KIND_LONG_PRESS   = 2'd0,
    KIND_LONG_RELEASE = 2'd1,
    KIND_SHORT_SEQ    = 2'd2
  } event_kind_e;

  typedef enum logic {
    REG_DEBOUNCE_THRESHOLD = 1'b0,
    REG_GAP_TICKS          = 1'b1
  } reg_idx_e;

  localparam int unsigned THR_W        = 4;
  localparam int unsigned GAP_W        = 8;
  localparam int unsigned CNT_OUT_W    = 4;
  localparam int unsigned CFG_W        = 8;
  localparam logic [THR_W-1:0] THR_RST = 4'd4;
  localparam logic [GAP_W-1:0] GAP_RST = 8'd20;
  localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = 4'd15;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    event_kind_e            kind;
    logic [CNT_OUT_W-1:0]   clicks;
    logic                   held;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic    push1st;
    logic    push2nd;
    result_t beat0;
    result_t beat1;
  } push_t;

endpackage
`default_nettype wire

FILE: rtl/button_click_discriminator_top.sv
// Top level of the button click discriminator.
// Usage: one raw button sample per beat on the input channel (in_valid_i,
// in_ready_o, button_level_i); each beat is one tick. Result beats leave on
// the output channel (out_valid_o, out_ready_i) carrying event_kind_o,
// click_count_o, held_after_o and last_o; last_o marks the final beat of a
// tick. A tick gives no beat, one, or two (timer expiry, then long release).
// Path: an accepted sample sits in the input register while the step logic
// writes its result beats into the queue, whose head drives the output channel.
// Throughput: one sample per cycle while the queue has room, set by the step logic;
// a tick with two results leaves as two beats through the four-beat queue.
// Stall: a sample waits in the input register while the queue has fewer than
// two free slots, and the input is refused while it waits; the head beat
// holds until taken.
// Configuration: cfg_we_i writes register cfg_idx_i (0 debounce threshold,
// 1 gap ticks) at once; the user writes only while the block is idle, which the block does not enforce.
// Reset: clears the debouncer, timer, click count and queue; the threshold
// returns to 4 and the gap to 20 ticks.
`default_nettype none
module button_click_discriminator_top
  import bcd_pkg::*;
#(
  parameter int unsigned MAX_CLICKS = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              button_level_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             event_kind_o,
  output logic [3:0]             click_count_o,
  output logic                   held_after_o,
  output logic                   last_o
);

  push_t   push;
  logic    room;
  result_t head;

  bcd_core #(
    .MAX_CLICKS(MAX_CLICKS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .level_i    (button_level_i),
    .room_i     (room),
    .push_o     (push)
  );

  bcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign event_kind_o  = head.kind;
  assign click_count_o = head.clicks;
  assign held_after_o  = head.held;
  assign last_o        = head.last;

endmodule
`default_nettype wire

FILE: rtl/bcd_queue.sv
// Result queue: takes up to two beats per cycle, hands out one per cycle while out_ready_i is high.
`default_nettype none
module bcd_queue
  import bcd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire push_t   push_i,
  output logic         room_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      head_o
);

  result_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]    cnt_q, cnt_d;
  logic                 pop;
  logic [QCNT_W-1:0]    n_push;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign room_o      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign n_push      = QCNT_W'(push_i.push1st) + QCNT_W'(push_i.push2nd);

  always_comb begin
    wr_d  = wr_q + QPTR_W'(n_push);
    rd_d  = rd_q + QPTR_W'(pop);
    cnt_d = cnt_q + n_push - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push1st) begin
      mem_q[wr_q] <= push_i.beat0;
    end
    if (push_i.push2nd) begin
      mem_q[wr_q + QPTR_W'(1)] <= push_i.beat1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bcd_core.sv
// Input register, configuration registers, the per-tick timer, debouncer and click counter, and the result beats.
`default_nettype none
module bcd_core
  import bcd_pkg::*;
#(
  parameter int unsigned MAX_CLICKS = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              level_i,
  input  wire logic              room_i,
  output push_t                  push_o
);

  localparam int unsigned CW  = $clog2(MAX_CLICKS + 1);
  localparam int unsigned CWX = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  logic [THR_W-1:0] thr_q;
  logic [GAP_W-1:0] gap_q;

  logic             iv_q;
  logic             lvl_q;
  logic             go;

  logic [THR_W-1:0] lc_q, lc_d;
  logic             seq_q, seq_d;
  logic             pend_q, pend_d;
  logic [GAP_W-1:0] gcnt_q, gcnt_d;
  logic [CW-1:0]    clk_q, clk_d;
  logic             hold_q, hold_d;

  logic [THR_W-1:0] thr;
  logic             expire, pressed, released, long_rel;
  logic [CWX-1:0]   clk_ext;
  logic [CNT_OUT_W-1:0] clk_sat;
  result_t          r_exp, r_rel;

  assign go         = iv_q && room_i;
  assign in_ready_o = !iv_q || go;
  assign thr        = (thr_q == '0) ? THR_W'(1) : thr_q;

  assign clk_ext = CWX'(clk_q);
  assign clk_sat = (clk_ext > CWX'(CNT_OUT_MAX)) ? CNT_OUT_MAX : clk_ext[CNT_OUT_W-1:0];

  always_comb begin
    seq_d    = seq_q;
    pend_d   = pend_q;
    gcnt_d   = gcnt_q;
    clk_d    = clk_q;
    hold_d   = hold_q;
    lc_d     = lc_q;
    pressed  = 1'b0;
    released = 1'b0;
    long_rel = 1'b0;
    expire   = pend_q && (gcnt_q <= GAP_W'(1));

    r_exp.kind   = (clk_q == '0) ? KIND_LONG_PRESS : KIND_SHORT_SEQ;
    r_exp.clicks = (clk_q == '0) ? '0 : clk_sat;
    r_exp.held   = (clk_q != '0) && hold_q;
    r_exp.last   = 1'b1;

    // gap timer
    if (pend_q) begin
      if (expire) begin
        gcnt_d = '0;
        pend_d = 1'b0;
        if (clk_q != '0) begin
          if (!hold_q) begin
            seq_d = 1'b0;
          end
          clk_d = '0;
        end
      end else begin
        gcnt_d = gcnt_q - GAP_W'(1);
      end
    end

    // debouncer
    if (lvl_q) begin
      if (lc_q < thr) begin
        lc_d    = lc_q + THR_W'(1);
        pressed = (lc_d == thr);
      end
    end else if (lc_q != '0) begin
      lc_d     = lc_q - THR_W'(1);
      released = (lc_d == '0);
    end

    if (pressed) begin
      hold_d = 1'b1;
      if (!seq_d || pend_d) begin
        gcnt_d = gap_q;
        pend_d = 1'b1;
      end
      seq_d = 1'b1;
    end else if (released) begin
      hold_d = 1'b0;
      if (seq_d) begin
        if (!pend_d) begin
          long_rel = 1'b1;
          seq_d    = 1'b0;
          clk_d    = '0;
        end else begin
          if (clk_d < CW'(MAX_CLICKS)) begin
            clk_d = clk_d + CW'(1);
          end
          gcnt_d = gap_q;
          pend_d = 1'b1;
        end
      end
    end

    r_rel.kind   = KIND_LONG_RELEASE;
    r_rel.clicks = '0;
    r_rel.held   = 1'b0;
    r_rel.last   = 1'b1;

    push_o.push1st = go && (expire || long_rel);
    push_o.push2nd = go && expire && long_rel;
    push_o.beat0   = expire ? r_exp : r_rel;
    push_o.beat1   = r_rel;
    if (expire && long_rel) begin
      push_o.beat0.last = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RST;
      gap_q  <= GAP_RST;
      iv_q   <= 1'b0;
      lc_q   <= '0;
      seq_q  <= 1'b0;
      pend_q <= 1'b0;
      gcnt_q <= '0;
      clk_q  <= '0;
      hold_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_DEBOUNCE_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
          REG_GAP_TICKS:          gap_q <= cfg_data_i[GAP_W-1:0];
          default:                thr_q <= thr_q;
        endcase
      end
      if (in_ready_o) begin
        iv_q <= in_valid_i;
      end
      if (go) begin
        lc_q   <= lc_d;
        seq_q  <= seq_d;
        pend_q <= pend_d;
        gcnt_q <= gcnt_d;
        clk_q  <= clk_d;
        hold_q <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      lvl_q <= level_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bcd_checker.sv
// Port-level checker for the button click discriminator, bound to the top level.
`default_nettype none
module bcd_checker
  import bcd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [1:0]        event_kind_o,
  input wire logic [3:0]        click_count_o,
  input wire logic              held_after_o,
  input wire logic              last_o
);

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_kind_o == KIND_LONG_PRESS || event_kind_o == KIND_LONG_RELEASE ||
                     event_kind_o == KIND_SHORT_SEQ))
    else $error("illegal event kind");

  a_long_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o != KIND_SHORT_SEQ) |-> (click_count_o == '0 && !held_after_o))
    else $error("long event carries clicks or held flag");

  a_short_clicks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == KIND_SHORT_SEQ) |-> (click_count_o != '0))
    else $error("short sequence without clicks");

  a_first_not_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (event_kind_o != KIND_LONG_RELEASE))
    else $error("long release not final beat of a tick");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");

endmodule

bind button_click_discriminator_top bcd_checker u_bcd_checker (.*);
`default_nettype wire
